[design/tt_element_evaluate_unit_macros.svh]
// Assertion macros used by the checker of the tensor-train evaluator.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TT_ELEMENT_EVALUATE_UNIT_MACROS_SVH
`define TT_ELEMENT_EVALUATE_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define TTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tte assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define TTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tte assertion failed");

`endif

[design/tte_pkg.sv]
// Shared constants and types of the tensor-train element evaluator.
// No dependencies; used by the core store, the MAC unit and the top level of the block.
package tte_pkg;

  localparam int DEF_MAX_DIMS  = 8;
  localparam int DEF_MODE_SIZE = 16;
  localparam int DEF_MAX_RANK  = 8;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // 1.0 in Q16.16, used to pass a core word unchanged through the multiplier.
  localparam logic signed [DATA_W-1:0] ONE_Q16 = DATA_W'(1) <<< FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // Control that travels with one operand pair into the MAC unit.
  typedef struct packed {
    logic vld;
    logic col_end;
  } mac_ctrl_t;

  // One finished vector entry from the MAC unit.
  typedef struct packed {
    logic                     vld;
    logic                     sat;
    logic signed [DATA_W-1:0] value;
  } mac_res_t;

endpackage

[design/tte_core_mem.sv]
// Core store of the evaluator: one write port, one read port, registered read.
// Depends on tte_pkg for the word width.
module tte_core_mem
  import tte_pkg::*;
#(
  parameter int AW = 13
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [2**AW];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/tte_mac.sv]
// Shared multiply-accumulate unit: Q16.16 product, floor, wide sum, clamp.
// Depends on tte_pkg for widths and the control and result structs.
module tte_mac
  import tte_pkg::*;
#(
  parameter int MAX_RANK = DEF_MAX_RANK
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] vec_i,
  input  logic signed [DATA_W-1:0] word_i,
  output mac_res_t                 res_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int ACC_W  = TERM_W + $clog2(MAX_RANK + 1) + 1;

  logic signed [PROD_W-1:0] prod_q;
  mac_ctrl_t                ctrl_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  sum;
  logic                     fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= vec_i * word_i;
    end
  end

  // Dropping the low fraction bits of a two's complement product floors it.
  assign term = prod_q[PROD_W-1:FRAC_W];
  assign sum  = acc_q + ACC_W'(term);
  assign fits = (sum[ACC_W-1:DATA_W-1] == '0) || (sum[ACC_W-1:DATA_W-1] == '1);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_q.vld) begin
      acc_d = ctrl_q.col_end ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    res_o.vld = ctrl_q.vld && ctrl_q.col_end;
    res_o.sat = !fits;
    if (fits) begin
      res_o.value = sum[DATA_W-1:0];
    end else if (sum[ACC_W-1]) begin
      res_o.value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_o.value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

[design/tt_element_evaluate_unit.sv]
// A write beat (cmd 0) stores one core word without stalling the input. An evaluate
// beat (cmd 1) runs one dimension of the tensor-train product through a single
// shared multiply-accumulate unit that takes one core word per cycle from the core
// store's read port: the first dimension loads MAX_RANK words, every later one
// computes MAX_RANK*MAX_RANK products, and the block stalls its input until the
// step has drained and finished. The result beat leaves through an output register;
// an ending step waits only if that register still holds an untaken beat. The core
// store has no reset.
module tt_element_evaluate_unit
  import tte_pkg::*;
#(
  parameter int MAX_DIMS  = DEF_MAX_DIMS,
  parameter int MODE_SIZE = DEF_MODE_SIZE,
  parameter int MAX_RANK  = DEF_MAX_RANK
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [2:0]               dim_sel_i,
  input  logic [2:0]               row_i,
  input  logic [3:0]               mode_index_i,
  input  logic [2:0]               col_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_dim_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] element_value_o,
  output logic                     saturated_o
);

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int MW = $clog2(MODE_SIZE);
  localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CW = $clog2(MAX_RANK + 1);
  localparam int AW = DW + MW + 2 * RW;
  localparam logic [RW-1:0] R_LAST   = RW'(MAX_RANK - 1);
  localparam logic [DW-1:0] D_LAST   = DW'(MAX_DIMS - 1);
  localparam logic [CW-1:0] R_COUNT  = CW'(MAX_RANK);

  state_e state_q, state_d;

  logic [DW-1:0] step_q;
  logic [MW-1:0] mode_q;
  logic          zero_q;
  logic          last_q;
  logic          load_q;
  logic          sat_q;
  logic [RW-1:0] i_q;
  logic [RW-1:0] j_q;
  logic [CW-1:0] res_cnt_q;
  mac_ctrl_t     rd_ctrl_q;
  mac_ctrl_t     issue_ctrl;

  logic signed [DATA_W-1:0] vec_q [MAX_RANK];
  logic signed [DATA_W-1:0] nxt_q [MAX_RANK];

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_sat_q;

  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] mac_vec;
  logic signed [DATA_W-1:0] mac_word;
  mac_res_t          mac_res;
  logic              emit;
  logic              finish_go;

  logic [5:0] dim_ext;
  logic [8:0] mode_ext;
  logic [6:0] row_ext;
  logic [6:0] col_ext;

  assign dim_ext  = 6'(dim_sel_i);
  assign mode_ext = 9'(mode_index_i);
  assign row_ext  = 7'(row_i);
  assign col_ext  = 7'(col_i);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Writes outside the configured store shape are dropped.
  assign wr_en   = accept && !cmd_i && (32'(dim_sel_i) < MAX_DIMS) &&
                   (32'(mode_index_i) < MODE_SIZE) && (32'(row_i) < MAX_RANK) &&
                   (32'(col_i) < MAX_RANK);
  assign wr_addr = {dim_ext[DW-1:0], mode_ext[MW-1:0], row_ext[RW-1:0], col_ext[RW-1:0]};

  assign rd_en   = (state_q == ST_ISSUE);
  assign rd_addr = {step_q, mode_q, i_q, j_q};

  tte_core_mem #(
    .AW (AW)
  ) u_core_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // A first-dimension load passes each word through the multiplier times one.
  assign mac_vec  = load_q ? ONE_Q16 : vec_q[0];
  assign mac_word = zero_q ? '0 : rd_data;

  tte_mac #(
    .MAX_RANK (MAX_RANK)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rd_ctrl_q),
    .vec_i  (mac_vec),
    .word_i (mac_word),
    .res_o  (mac_res)
  );

  assign issue_ctrl.vld     = rd_en;
  assign issue_ctrl.col_end = load_q || (i_q == R_LAST);

  assign emit      = last_q || (step_q == D_LAST);
  assign finish_go = !emit || !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (j_q == R_LAST && (load_q || i_q == R_LAST)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_cnt_q == R_COUNT) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      mode_q    <= '0;
      zero_q    <= 1'b0;
      last_q    <= 1'b0;
      load_q    <= 1'b0;
      sat_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      res_cnt_q <= '0;
      rd_ctrl_q <= '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        vec_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rd_ctrl_q <= issue_ctrl;

      if (accept && cmd_i) begin
        mode_q    <= mode_ext[MW-1:0];
        zero_q    <= (32'(mode_index_i) >= MODE_SIZE);
        last_q    <= last_dim_i;
        load_q    <= (step_q == '0);
        i_q       <= '0;
        j_q       <= '0;
        res_cnt_q <= '0;
      end

      // Products run row index fastest; a load walks only row 0.
      if (state_q == ST_ISSUE) begin
        if (load_q || i_q == R_LAST) begin
          i_q <= '0;
          j_q <= j_q + RW'(1);
        end else begin
          i_q <= i_q + RW'(1);
        end
      end

      // The vector rotates once per product so that entry i sits at the head.
      if (rd_ctrl_q.vld && !load_q) begin
        for (int k = 0; k < MAX_RANK - 1; k++) begin
          vec_q[k] <= vec_q[k+1];
        end
        vec_q[MAX_RANK-1] <= vec_q[0];
      end

      if (mac_res.vld) begin
        res_cnt_q <= res_cnt_q + CW'(1);
        sat_q     <= sat_q | mac_res.sat;
      end

      if (state_q == ST_FINISH && finish_go) begin
        if (emit) begin
          step_q <= '0;
          sat_q  <= 1'b0;
          for (int k = 0; k < MAX_RANK; k++) begin
            vec_q[k] <= '0;
          end
        end else begin
          step_q <= step_q + DW'(1);
          for (int k = 0; k < MAX_RANK; k++) begin
            vec_q[k] <= nxt_q[k];
          end
        end
      end
    end
  end

  // New entries enter at the top, so entry 0 ends up at index 0.
  always_ff @(posedge clk_i) begin
    if (mac_res.vld) begin
      for (int k = 0; k < MAX_RANK - 1; k++) begin
        nxt_q[k] <= nxt_q[k+1];
      end
      nxt_q[MAX_RANK-1] <= mac_res.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && finish_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && finish_go && emit) begin
      out_value_q <= nxt_q[0];
      out_sat_q   <= sat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_value_o = out_value_q;
  assign saturated_o     = out_sat_q;

endmodule

[design/tte_checker.sv]
// Port-level checks on the tensor-train evaluator, bound to its top level.
// Depends on tt_element_evaluate_unit_macros.svh for the assertion macros.
`include "tt_element_evaluate_unit_macros.svh"

module tte_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic cmd_i,
  input logic out_valid_o,
  input logic out_stall_i
);

  logic wr_beat;
  logic eval_beat;

  assign wr_beat   = in_valid_i && !in_stall_o && !cmd_i;
  assign eval_beat = in_valid_i && !in_stall_o && cmd_i;

  // A result beat is held until it is taken.
  `TTE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // A write beat never produces a result.
  `TTE_ASSERT_NEXT(a_wr_no_result, wr_beat && !out_valid_o, !out_valid_o)
  // A write beat does not stall the input for the following beat.
  `TTE_ASSERT_NEXT(a_wr_one_cycle, wr_beat, !in_stall_o)
  // An evaluate beat keeps the block busy after it is taken.
  `TTE_ASSERT_NEXT(a_eval_busy, eval_beat, in_stall_o)
  // A result appears only at the end of an evaluation step.
  `TTE_ASSERT_NOW(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind tt_element_evaluate_unit tte_checker u_tte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
